[sv/wfba_pkg.sv]
`timescale 1ns / 1ps
// Shared package for the worst-fit block allocator: sizes, status codes,
// controller states and the structs between the controller and the scan unit.
// No dependencies.
package wfba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int SLOT_BITS  = $clog2(MAX_BLOCKS);
    localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);
    localparam int LABEL_BITS = 16;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_REQ = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_GRANTED = 2'd1,
        ST_NONE    = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_LATCH,
        S_FIN
    } t_state;

    typedef struct packed {
        logic                 clr;
        logic                 vld;
        logic [SLOT_BITS-1:0] slot;
    } t_scan_ctl;

    typedef struct packed {
        logic                 found;
        logic [SLOT_BITS-1:0] slot;
        logic [SIZE_BITS-1:0] left;
    } t_scan_res;

endpackage

[sv/wfba_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module wfba_ram #(
    parameter int W = 16,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/wfba_scan.sv]
`timescale 1ns / 1ps
// Worst-fit scan unit: folds one free size per cycle into the running best.
// Depends on wfba_pkg.
module wfba_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wfba_pkg::t_scan_ctl           i_ctl,
    input  logic [wfba_pkg::SIZE_BITS-1:0] i_amount,
    input  logic [wfba_pkg::SIZE_BITS-1:0] i_rdata,
    output wfba_pkg::t_scan_res           o_res
);

    logic                           r_found;
    logic [wfba_pkg::SLOT_BITS-1:0] r_slot;
    logic [wfba_pkg::SIZE_BITS-1:0] r_left;
    logic [wfba_pkg::SIZE_BITS-1:0] w_left;
    logic                           w_take;

    assign w_left = i_rdata - i_amount;
    // A slot is taken if it fits and strictly beats the best so far, so the
    // lowest slot wins a tie.
    assign w_take = i_ctl.vld && (i_amount <= i_rdata) && (!r_found || (w_left > r_left));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clr) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_slot <= i_ctl.slot;
            r_left <= w_left;
        end
    end

    assign o_res.found = r_found;
    assign o_res.slot  = r_slot;
    assign o_res.left  = r_left;

endmodule

[sv/worst_fit_block_allocator.sv]
`timescale 1ns / 1ps
// Worst-fit block allocator top level: controller, table memories, output stage.
// Depends on wfba_pkg, wfba_ram and wfba_scan.
//
// Usage. Items enter on the input channel (i_valid / o_stall) and one result
// item leaves on the output channel (o_valid / i_stall) for every input item.
// An item is taken at a clock edge where valid is high and stall is low.
// An add item (kind 0) appends a block with its label and size to the next
// slot, or answers "table full" once every slot is loaded. A request item
// (kind 1) scans the loaded slots for the block that leaves the most space
// after the request, lowest slot first on a tie, and subtracts the request.
// Add items and requests on an empty table go straight to the hand-off.
// A granted request makes one free-size memory read per loaded slot, folds
// in the last read, then does the pick, the label read and the hand-off to
// the output register. A request that no block can hold skips the label read.
// The rate is set by the single read port of the free-size memory.
// The output register holds a finished result while the receiver stalls, so
// the next item is accepted and worked on meanwhile; it waits only at the
// hand-off until the previous result is taken.
// Reset (synchronous, active low) empties the table and drops any pending
// result. The table memories are never cleared: only loaded slots are read.
module worst_fit_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [15:0] i_block_label,
    input  logic [15:0] i_amount,
    input  logic [15:0] i_request_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_echo_id,
    output logic [15:0] o_granted_label,
    output logic [3:0]  o_granted_slot,
    output logic [15:0] o_free_left
);

    localparam int SB = wfba_pkg::SIZE_BITS;
    localparam int AB = wfba_pkg::SLOT_BITS;
    localparam int CB = wfba_pkg::CNT_BITS;
    localparam int LB = wfba_pkg::LABEL_BITS;

    // Control state.
    wfba_pkg::t_state r_state, n_state;
    logic [CB-1:0]    r_used, n_used;
    logic             r_out_valid, n_out_valid;
    logic             r_dv;

    // Working and result payload.
    logic [AB-1:0]    r_idx, n_idx;
    logic [AB-1:0]    r_dslot;
    logic [SB-1:0]    r_amount, n_amount;
    logic [15:0]      r_echo, n_echo;
    wfba_pkg::t_status r_res_status, n_res_status;
    logic [LB-1:0]    r_res_label, n_res_label;
    logic [AB-1:0]    r_res_slot, n_res_slot;
    logic [SB-1:0]    r_res_left, n_res_left;
    logic [1:0]       r_out_status;
    logic [15:0]      r_out_echo;
    logic [15:0]      r_out_label;
    logic [3:0]       r_out_slot;
    logic [15:0]      r_out_left;

    // Handshake and memory signals.
    logic             w_in_acc;
    logic             w_full;
    logic             w_load;
    logic [CB-1:0]    w_used_m1;
    logic [SB-1:0]    w_amount_sz;
    logic             w_add_wr;
    logic             w_free_we;
    logic [AB-1:0]    w_free_waddr;
    logic [SB-1:0]    w_free_wdata;
    logic [SB-1:0]    w_free_rdata;
    logic [LB-1:0]    w_label_rdata;
    logic             w_clr;
    wfba_pkg::t_scan_ctl w_scan_ctl;
    wfba_pkg::t_scan_res w_scan_res;

    assign o_stall     = (r_state != wfba_pkg::S_IDLE);
    assign w_in_acc    = i_valid && !o_stall;
    assign w_full      = (r_used == CB'(wfba_pkg::MAX_BLOCKS));
    assign w_used_m1   = r_used - CB'(1);
    assign w_amount_sz = SB'(i_amount);

    // An add is written into both tables in the cycle it is accepted.
    assign w_add_wr = w_in_acc && (i_kind == wfba_pkg::KIND_ADD) && !w_full;
    assign w_clr    = w_in_acc && (i_kind == wfba_pkg::KIND_REQ);

    // The free-size table has one write port, shared by appends and by the
    // write-back of a grant; the two never fall in the same state.
    always_comb begin
        w_free_we    = 1'b0;
        w_free_waddr = r_used[AB-1:0];
        w_free_wdata = w_amount_sz;
        if (w_add_wr) begin
            w_free_we = 1'b1;
        end else if (r_state == wfba_pkg::S_PICK && w_scan_res.found) begin
            w_free_we    = 1'b1;
            w_free_waddr = w_scan_res.slot;
            w_free_wdata = w_scan_res.left;
        end
    end

    wfba_ram #(.W(SB), .D(wfba_pkg::MAX_BLOCKS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_free_we),
        .i_waddr (w_free_waddr),
        .i_wdata (w_free_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_free_rdata)
    );

    // The label table is read at the chosen slot; the data is taken in the
    // cycle after the pick.
    wfba_ram #(.W(LB), .D(wfba_pkg::MAX_BLOCKS)) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (w_add_wr),
        .i_waddr (r_used[AB-1:0]),
        .i_wdata (i_block_label),
        .i_raddr (w_scan_res.slot),
        .o_rdata (w_label_rdata)
    );

    assign w_scan_ctl.clr  = w_clr;
    assign w_scan_ctl.vld  = r_dv;
    assign w_scan_ctl.slot = r_dslot;

    wfba_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_scan_ctl),
        .i_amount (r_amount),
        .i_rdata  (w_free_rdata),
        .o_res    (w_scan_res)
    );

    // The pending result moves to the output register once that is free.
    assign w_load = (r_state == wfba_pkg::S_FIN) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_idx        = r_idx;
        n_amount     = r_amount;
        n_echo       = r_echo;
        n_res_status = r_res_status;
        n_res_label  = r_res_label;
        n_res_slot   = r_res_slot;
        n_res_left   = r_res_left;
        n_out_valid  = r_out_valid && i_stall;
        case (r_state)
            wfba_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_echo      = i_request_id;
                    n_amount    = w_amount_sz;
                    n_res_label = '0;
                    n_res_slot  = '0;
                    n_res_left  = '0;
                    n_idx       = '0;
                    n_state     = wfba_pkg::S_FIN;
                    if (i_kind == wfba_pkg::KIND_ADD) begin
                        if (w_full) begin
                            n_res_status = wfba_pkg::ST_FULL;
                        end else begin
                            n_res_status = wfba_pkg::ST_ADDED;
                            n_res_slot   = r_used[AB-1:0];
                            n_res_left   = w_amount_sz;
                            n_used       = r_used + CB'(1);
                        end
                    end else begin
                        n_res_status = wfba_pkg::ST_NONE;
                        if (r_used != '0) begin
                            n_state = wfba_pkg::S_SCAN;
                        end
                    end
                end
            end
            wfba_pkg::S_SCAN: begin
                if (r_idx == w_used_m1[AB-1:0]) begin
                    n_state = wfba_pkg::S_DRAIN;
                end else begin
                    n_idx = r_idx + AB'(1);
                end
            end
            wfba_pkg::S_DRAIN: begin
                n_state = wfba_pkg::S_PICK;
            end
            wfba_pkg::S_PICK: begin
                if (w_scan_res.found) begin
                    n_res_status = wfba_pkg::ST_GRANTED;
                    n_res_slot   = w_scan_res.slot;
                    n_res_left   = w_scan_res.left;
                    n_state      = wfba_pkg::S_LATCH;
                end else begin
                    n_state = wfba_pkg::S_FIN;
                end
            end
            wfba_pkg::S_LATCH: begin
                n_res_label = w_label_rdata;
                n_state     = wfba_pkg::S_FIN;
            end
            wfba_pkg::S_FIN: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = wfba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wfba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wfba_pkg::S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_dv        <= (r_state == wfba_pkg::S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_dslot      <= r_idx;
        r_amount     <= n_amount;
        r_echo       <= n_echo;
        r_res_status <= n_res_status;
        r_res_label  <= n_res_label;
        r_res_slot   <= n_res_slot;
        r_res_left   <= n_res_left;
        if (w_load) begin
            r_out_status <= r_res_status;
            r_out_echo   <= r_echo;
            r_out_label  <= 16'(r_res_label);
            r_out_slot   <= 4'(r_res_slot);
            r_out_left   <= 16'(r_res_left);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_echo_id       = r_out_echo;
    assign o_granted_label = r_out_label;
    assign o_granted_slot  = r_out_slot;
    assign o_free_left     = r_out_left;

    // The fill count never passes the table size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CB'(wfba_pkg::MAX_BLOCKS))
        else $error("slot count exceeds table size");

    // An accepted add on a table with room grows the fill count by one.
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_add_wr |=> (r_used == $past(r_used) + CB'(1)))
        else $error("add item did not advance the slot count");

    // A chosen block always lies among the loaded slots.
    a_pick_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wfba_pkg::S_PICK && w_scan_res.found) |->
        (CB'(w_scan_res.slot) < r_used))
        else $error("chosen slot is not loaded");

endmodule
